// ===== sv/msiva_pkg.sv =====
// Shared types and constants of the MSI vector allocator.
package msiva_pkg;

  localparam int unsigned VECTORS  = 1024;
  localparam int unsigned IDX_W    = $clog2(VECTORS);
  localparam int unsigned USED_W   = 11;
  localparam int unsigned CNT_W    = 12;
  localparam int unsigned ID_W     = 24;
  localparam int unsigned SUM_W    = ID_W + 1;
  localparam logic [ID_W-1:0] FIRST_ID = 24'd8192;
  localparam logic [47:0] TRANSLATE_OFFSET = 48'h0000;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 328;

  typedef enum logic [2:0] {
    REQ_ALLOC_MSI    = 3'd0,
    REQ_RELEASE_MSI  = 3'd1,
    REQ_ALLOC_MSIX   = 3'd2,
    REQ_RELEASE_MSIX = 3'd3,
    REQ_MAP          = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_INVALID   = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_BUSY      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    FSM_CLEAR, FSM_IDLE, FSM_CHECK, FSM_READ, FSM_EVAL, FSM_POST, FSM_FILL, FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic        used;
    logic        msix;
    logic [31:0] dev;
    logic [31:0] ev;
  } entry_t;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic rd;
    logic eval;
    logic fill_wr;
    logic k_zero;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic early_done;
    logic eval_last;
    logic need_fill;
    logic fill_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/msiva_ctrl.sv =====
// Request sequencer of the MSI vector allocator.
module msiva_ctrl import msiva_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      FSM_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_nxt = FSM_IDLE;
      end
      FSM_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = FSM_CHECK;
        end
      end
      FSM_CHECK: begin
        state_nxt = sts.early_done ? FSM_DONE : FSM_READ;
      end
      FSM_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = FSM_EVAL;
      end
      FSM_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.eval_last ? FSM_POST : FSM_READ;
      end
      FSM_POST: begin
        cmd.k_zero = 1'b1;
        state_nxt  = sts.need_fill ? FSM_FILL : FSM_DONE;
      end
      FSM_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) state_nxt = FSM_DONE;
      end
      FSM_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_CLEAR;
    endcase
  end

endmodule

// ===== sv/msiva_dp.sv =====
// Vector table, scan registers, counters and result register.
module msiva_dp import msiva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [2:0]            in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_index,
  input  logic [47:0]           cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  entry_t mem [VECTORS];
  entry_t rd_q;

  logic [47:0]       base_r;
  logic [31:0]       fsize_r;
  logic [2:0]        req_r;
  logic [31:0]       dev_r, ev_r;
  logic [CNT_W-1:0]  cnt_r, k_r, freed_r;
  logic [ID_W-1:0]   id_r;
  logic [USED_W-1:0] run_r, used_r;
  logic [IDX_W-1:0]  start_r;
  logic              found_r, busy_r, hit_r;
  logic [31:0]       data_r;
  logic [31:0]       stat_r [6];
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_r;

  logic              ready;
  logic [SUM_W-1:0]  sum;
  logic              in_rng;
  logic [IDX_W-1:0]  tab_addr, rd_addr, wr_addr;
  logic              we;
  entry_t            wd;
  logic              k_end, run_hit, rel_hit;
  logic [CNT_W-1:0]  cnt_m1;

  assign ready    = (base_r != '0) && (fsize_r != '0);
  assign sum      = {1'b0, id_r} + SUM_W'(k_r);
  assign in_rng   = (sum >= SUM_W'(FIRST_ID)) && (sum < SUM_W'(FIRST_ID) + SUM_W'(VECTORS));
  assign tab_addr = IDX_W'(sum - SUM_W'(FIRST_ID));
  assign k_end    = (k_r == CNT_W'(VECTORS - 1));
  assign cnt_m1   = cnt_r - 1'b1;
  assign run_hit  = !rd_q.used && ((CNT_W'(run_r) + 1'b1) == cnt_r);
  assign rel_hit  = in_rng && rd_q.used && (rd_q.dev == dev_r) &&
                    (rd_q.msix == (req_r == REQ_RELEASE_MSIX));
  assign rd_addr  = (req_r == REQ_ALLOC_MSI || req_r == REQ_ALLOC_MSIX) ? k_r[IDX_W-1:0]
                                                                       : tab_addr;

  always_comb begin
    we      = 1'b0;
    wr_addr = k_r[IDX_W-1:0];
    wd      = '0;
    if (cmd.clear_wr) begin
      we = 1'b1;
    end else if (cmd.fill_wr) begin
      we      = 1'b1;
      wr_addr = start_r + k_r[IDX_W-1:0];
      wd.used = 1'b1;
      wd.msix = (req_r == REQ_ALLOC_MSIX);
      wd.dev  = dev_r;
      wd.ev   = (req_r == REQ_ALLOC_MSIX) ? ev_r : 32'(k_r);
    end else if (cmd.eval && (req_r == REQ_RELEASE_MSI || req_r == REQ_RELEASE_MSIX)
                 && rel_hit) begin
      we      = 1'b1;
      wr_addr = tab_addr;
      wd      = rd_q;
      wd.used = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wd;
    if (cmd.rd) rd_q <= mem[rd_addr];
  end

  always_comb begin
    sts = '0;
    sts.clear_last = k_end;
    sts.out_free   = !out_valid_r || out_tready;
    case (req_r)
      REQ_ALLOC_MSI: begin
        sts.early_done = !ready || (cnt_r == '0) || (cnt_r > CNT_W'(VECTORS));
        sts.eval_last  = run_hit || k_end;
        sts.need_fill  = found_r;
        sts.fill_last  = (k_r == cnt_m1);
      end
      REQ_RELEASE_MSI: begin
        sts.early_done = (cnt_r == '0) || (id_r < FIRST_ID);
        sts.eval_last  = (k_r == cnt_m1);
      end
      REQ_ALLOC_MSIX: begin
        sts.early_done = !ready;
        sts.eval_last  = k_end;
        sts.need_fill  = found_r && !busy_r;
        sts.fill_last  = 1'b1;
      end
      REQ_RELEASE_MSIX, REQ_MAP: begin
        sts.early_done = !in_rng;
        sts.eval_last  = 1'b1;
      end
      default: sts.early_done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      fsize_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == 1'b0) base_r <= cfg_data;
      else fsize_r <= cfg_data[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.load || cmd.k_zero) begin
      k_r <= '0;
    end else if (cmd.clear_wr || cmd.eval || cmd.fill_wr) begin
      k_r <= k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_tuser;
      dev_r   <= in_tdata[31:0];
      cnt_r   <= in_tdata[43:32];
      ev_r    <= in_tdata[75:44];
      id_r    <= in_tdata[99:76];
      run_r   <= '0;
      start_r <= '0;
      found_r <= 1'b0;
      busy_r  <= 1'b0;
      hit_r   <= 1'b0;
      freed_r <= '0;
      data_r  <= '0;
    end else if (cmd.eval) begin
      case (req_r)
        REQ_ALLOC_MSI: begin
          if (rd_q.used) begin
            run_r <= '0;
          end else begin
            run_r <= run_r + 1'b1;
            if (run_r == '0) start_r <= k_r[IDX_W-1:0];
          end
          if (run_hit) found_r <= 1'b1;
        end
        REQ_ALLOC_MSIX: begin
          if (rd_q.used && rd_q.dev == dev_r && rd_q.ev == ev_r) busy_r <= 1'b1;
          if (!rd_q.used && !found_r) begin
            found_r <= 1'b1;
            start_r <= k_r[IDX_W-1:0];
          end
        end
        REQ_RELEASE_MSI, REQ_RELEASE_MSIX: begin
          if (rel_hit) freed_r <= freed_r + 1'b1;
        end
        REQ_MAP: begin
          hit_r  <= rd_q.used;
          data_r <= rd_q.ev;
        end
        default: ;
      endcase
    end
  end

  status_e           f_status;
  logic [ID_W-1:0]   f_granted;
  logic [47:0]       f_addr;
  logic [31:0]       f_data;
  logic [USED_W-1:0] f_used;
  logic [5:0]        f_inc;

  always_comb begin
    f_status  = ST_OK;
    f_granted = '0;
    f_addr    = '0;
    f_data    = '0;
    f_used    = used_r;
    f_inc     = '0;
    case (req_r)
      REQ_ALLOC_MSI: begin
        if (!ready) f_status = ST_NOT_READY;
        else if (cnt_r == '0) f_status = ST_INVALID;
        else if (cnt_r > CNT_W'(VECTORS)) begin
          f_status = ST_INVALID;
          f_inc[1] = 1'b1;
        end else if (!found_r) begin
          f_status = ST_NO_SPACE;
          f_inc[1] = 1'b1;
        end else begin
          f_granted = FIRST_ID + ID_W'(start_r);
          f_used    = used_r + cnt_r[USED_W-1:0];
          f_inc[0]  = 1'b1;
        end
      end
      REQ_RELEASE_MSI: begin
        f_used   = used_r - freed_r[USED_W-1:0];
        f_inc[4] = 1'b1;
      end
      REQ_ALLOC_MSIX: begin
        if (!ready) f_status = ST_NOT_READY;
        else if (busy_r) begin
          f_status = ST_BUSY;
          f_inc[3] = 1'b1;
        end else if (!found_r) begin
          f_status = ST_NO_SPACE;
          f_inc[3] = 1'b1;
        end else begin
          f_granted = FIRST_ID + ID_W'(start_r);
          f_addr    = base_r + TRANSLATE_OFFSET;
          f_data    = ev_r;
          f_used    = used_r + 1'b1;
          f_inc[2]  = 1'b1;
        end
      end
      REQ_RELEASE_MSIX: begin
        f_used   = used_r - freed_r[USED_W-1:0];
        f_inc[5] = 1'b1;
      end
      REQ_MAP: begin
        if (!in_rng || !hit_r) f_status = ST_INVALID;
        else if (!ready) f_status = ST_NOT_READY;
        else begin
          f_addr = base_r + TRANSLATE_OFFSET;
          f_data = data_r;
        end
      end
      default: f_status = ST_INVALID;
    endcase
  end

  logic [31:0] stat_nxt [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      stat_nxt[i] = stat_r[i];
      if (f_inc[i]) begin
        stat_nxt[i] = (i >= 4) ? stat_r[i] + 32'(freed_r) : stat_r[i] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) stat_r[i] <= '0;
    end else if (cmd.finish) begin
      used_r      <= f_used;
      out_valid_r <= 1'b1;
      for (int i = 0; i < 6; i++) stat_r[i] <= stat_nxt[i];
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= {6'd0, stat_nxt[5], stat_nxt[4], stat_nxt[3], stat_nxt[2], stat_nxt[1],
                stat_nxt[0], f_used, freed_r, f_data, f_addr, f_granted, f_status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

// ===== sv/msi_vector_allocator.sv =====
// Top level of the MSI vector allocator.
//
// Input channel in_*: one request per transaction, in_tuser carries the request
// code and in_tdata the device, count, event and interrupt number.
// Result channel out_*: one result per request with status, grant, message
// address and data, freed count, used count and six statistics counters.
// Configuration channel cfg_*: always ready; index 0 writes the translate base,
// index 1 the frame size.
// One request at a time; each table read passes through a read state and an
// evaluate state on the single table read port.
// Work per request: map and release msix read and evaluate one entry, or
// none when rejected up front; release msi evaluates each entry of its range;
// allocate msix scans the full table plus one fill write, and allocate msi
// scans up to the full table plus a range fill; a stalled output adds its wait.
// After reset a clearing pass writes all 1024 table entries, one per cycle,
// before the first request is taken.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits for the register to empty before its own result.
module msi_vector_allocator import msiva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2:0]            in_tuser,  // req_type
  input  logic [IN_DATA_W-1:0]  in_tdata,  // device_id, vector_count, event_number, interrupt_id
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status, granted_id, msg_addr, msg_data, freed_count, used_vectors, msi_ok_total,
  // msi_fail_total, msix_ok_total, msix_fail_total, msi_freed_total, msix_freed_total
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [47:0]           cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  msiva_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msiva_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sv/msiva_checker.sv =====
// Port checker of the MSI vector allocator and its bind.
module msiva_checker import msiva_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_tready)
    else $error("request taken during clearing pass");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_BUSY)
    else $error("bad status code");

  a_grant_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[26:3] != '0 |-> out_tdata[118:107] == '0 &&
    out_tdata[2:0] == ST_OK)
    else $error("grant with freed entries or error status");

endmodule

bind msi_vector_allocator msiva_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/msi_vector_allocator_tb.sv =====
// Testbench for the MSI vector allocator: directed and random requests checked against a table model.
`timescale 1ns / 100ps

module msi_vector_allocator_tb;
  import msiva_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [31:0] msix_freed_total;
    logic [31:0] msi_freed_total;
    logic [31:0] msix_fail_total;
    logic [31:0] msix_ok_total;
    logic [31:0] msi_fail_total;
    logic [31:0] msi_ok_total;
    logic [10:0] used_vectors;
    logic [11:0] freed_count;
    logic [31:0] msg_data;
    logic [47:0] msg_addr;
    logic [23:0] granted_id;
    logic [2:0]  status;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [2:0]            in_tuser = '0;   // req_type
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // device_id, vector_count, event_number, interrupt_id
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // status, granted_id, msg_addr, msg_data, freed_count, used_vectors, msi_ok_total,
  // msi_fail_total, msix_ok_total, msix_fail_total, msi_freed_total, msix_freed_total
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index = 1'b0;
  logic [47:0]           cfg_data = '0;

  msi_vector_allocator dut (.*);

  always #5 clk = ~clk;

  // allocator table mirror
  bit          tbl_used [VECTORS];
  bit          tbl_msix [VECTORS];
  bit [31:0]   tbl_dev  [VECTORS];
  bit [31:0]   tbl_ev   [VECTORS];
  bit [10:0]   used_cnt;
  bit [31:0]   msi_ok, msi_fail, msix_ok, msix_fail, msi_freed, msix_freed;
  bit [47:0]   base_reg;
  bit [31:0]   frame_reg;

  result_t     pending_results [$];
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned mismatches;
  int unsigned cycles;
  bit [31:0]   dev_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'h0000_1234, 32'hA5C3_0F96};

  function automatic bit table_ready();
    return base_reg != 0 && frame_reg != 0;
  endfunction

  function automatic int first_free_run(int unsigned count);
    int unsigned run;
    int          s;
    run = 0;
    s = 0;
    for (int k = 0; k < VECTORS; k++) begin
      if (!tbl_used[k]) begin
        if (run == 0) s = k;
        run++;
        if (run == count) return s;
      end else begin
        run = 0;
      end
    end
    return -1;
  endfunction

  function automatic int used_index(bit [31:0] id);
    if (id < FIRST_ID || id >= FIRST_ID + VECTORS) return -1;
    if (!tbl_used[id - FIRST_ID]) return -1;
    return int'(id - FIRST_ID);
  endfunction

  function automatic bit event_taken(bit [31:0] dev, bit [31:0] ev);
    for (int k = 0; k < VECTORS; k++)
      if (tbl_used[k] && tbl_dev[k] == dev && tbl_ev[k] == ev) return 1'b1;
    return 1'b0;
  endfunction

  function automatic result_t serve_request(bit [2:0] req, bit [31:0] dev, bit [11:0] count,
                                            bit [31:0] ev, bit [23:0] id);
    result_t r;
    int      s;
    int      idx;
    r = '0;
    r.status = ST_OK;
    case (req)
      REQ_ALLOC_MSI: begin
        if (!table_ready()) r.status = ST_NOT_READY;
        else if (count == 0) r.status = ST_INVALID;
        else if (count > VECTORS) begin
          r.status = ST_INVALID;
          msi_fail++;
        end else begin
          s = first_free_run(count);
          if (s < 0) begin
            r.status = ST_NO_SPACE;
            msi_fail++;
          end else begin
            for (int k = 0; k < count; k++) begin
              tbl_used[s+k] = 1'b1;
              tbl_msix[s+k] = 1'b0;
              tbl_dev[s+k] = dev;
              tbl_ev[s+k] = k;
            end
            used_cnt += 11'(count);
            r.granted_id = 24'(FIRST_ID + s);
            msi_ok++;
          end
        end
      end
      REQ_RELEASE_MSI: begin
        if (count != 0 && id >= FIRST_ID)
          for (int k = 0; k < count; k++) begin
            idx = used_index(32'(id) + 32'(k));
            if (idx >= 0 && !tbl_msix[idx] && tbl_dev[idx] == dev) begin
              tbl_used[idx] = 1'b0;
              used_cnt--;
              r.freed_count++;
              msi_freed++;
            end
          end
      end
      REQ_ALLOC_MSIX: begin
        if (!table_ready()) r.status = ST_NOT_READY;
        else if (event_taken(dev, ev)) begin
          r.status = ST_BUSY;
          msix_fail++;
        end else begin
          s = first_free_run(1);
          if (s < 0) begin
            r.status = ST_NO_SPACE;
            msix_fail++;
          end else begin
            tbl_used[s] = 1'b1;
            tbl_msix[s] = 1'b1;
            tbl_dev[s] = dev;
            tbl_ev[s] = ev;
            used_cnt++;
            r.granted_id = 24'(FIRST_ID + s);
            r.msg_addr = base_reg + TRANSLATE_OFFSET;
            r.msg_data = ev;
            msix_ok++;
          end
        end
      end
      REQ_RELEASE_MSIX: begin
        idx = used_index(32'(id));
        if (idx >= 0 && tbl_msix[idx] && tbl_dev[idx] == dev) begin
          tbl_used[idx] = 1'b0;
          used_cnt--;
          r.freed_count = 12'd1;
          msix_freed++;
        end
      end
      REQ_MAP: begin
        idx = used_index(32'(id));
        if (idx < 0) r.status = ST_INVALID;
        else if (!table_ready()) r.status = ST_NOT_READY;
        else begin
          r.msg_addr = base_reg + TRANSLATE_OFFSET;
          r.msg_data = tbl_ev[idx];
        end
      end
      default: r.status = ST_INVALID;
    endcase
    r.used_vectors = used_cnt;
    r.msi_ok_total = msi_ok;
    r.msi_fail_total = msi_fail;
    r.msix_ok_total = msix_ok;
    r.msix_fail_total = msix_fail;
    r.msi_freed_total = msi_freed;
    r.msix_freed_total = msix_freed;
    return r;
  endfunction

  task automatic send_request(bit [2:0] req, bit [31:0] dev, bit [11:0] count,
                              bit [31:0] ev, bit [23:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {4'b0, id, ev, count, dev};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(serve_request(req, dev, count, ev, id));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_register(bit idx, bit [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == 1'b0) base_reg = value;
    else frame_reg = value[31:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h actual %0h", name, exp_v, act_v);
    end
  endtask

  always @(negedge clk)
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) begin
      result_t got, want;
      got = out_tdata[$bits(result_t)-1:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0h", got);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("granted_id", want.granted_id, got.granted_id);
        check_field("msg_addr", want.msg_addr, got.msg_addr);
        check_field("msg_data", want.msg_data, got.msg_data);
        check_field("freed_count", want.freed_count, got.freed_count);
        check_field("used_vectors", want.used_vectors, got.used_vectors);
        check_field("msi_ok_total", want.msi_ok_total, got.msi_ok_total);
        check_field("msi_fail_total", want.msi_fail_total, got.msi_fail_total);
        check_field("msix_ok_total", want.msix_ok_total, got.msix_ok_total);
        check_field("msix_fail_total", want.msix_fail_total, got.msix_fail_total);
        check_field("msi_freed_total", want.msi_freed_total, got.msi_freed_total);
        check_field("msix_freed_total", want.msix_freed_total, got.msix_freed_total);
      end
    end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_not_ready();
    send_request(REQ_ALLOC_MSI, 32'h1, 12'd4, 32'h0, 24'h0);
    send_request(REQ_ALLOC_MSIX, 32'h1, 12'd0, 32'h3, 24'h0);
    send_request(REQ_MAP, 32'h1, 12'd0, 32'h0, FIRST_ID);
    send_request(REQ_RELEASE_MSI, 32'h1, 12'd8, 32'h0, FIRST_ID);
    send_request(3'd5, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_request(3'd6, 32'h0, 12'h0, 32'h0, 24'h0);
    send_request(3'd7, 32'h0, 12'h0, 32'h0, 24'h0);
    drain_results();
  endtask

  task automatic test_directed();
    write_register(1'b0, 48'hFFFF_FFFF_FFFF);
    write_register(1'b1, 48'hFFFF_FFFF);
    send_request(REQ_ALLOC_MSI, 32'h7, 12'd0, 32'h0, 24'h0);
    send_request(REQ_ALLOC_MSI, 32'h7, 12'd1025, 32'h0, 24'h0);
    send_request(REQ_ALLOC_MSI, 32'h7, 12'hFFF, 32'h0, 24'h0);
    send_request(REQ_ALLOC_MSI, 32'h7, 12'd1024, 32'h0, 24'h0);
    send_request(REQ_ALLOC_MSIX, 32'h8, 12'd0, 32'h1, 24'h0);
    send_request(REQ_ALLOC_MSI, 32'h8, 12'd1, 32'h0, 24'h0);
    send_request(REQ_ALLOC_MSIX, 32'h7, 12'd0, 32'h5, 24'h0);
    send_request(REQ_MAP, 32'h0, 12'd0, 32'h0, 24'(FIRST_ID + 5));
    send_request(REQ_MAP, 32'h0, 12'd0, 32'h0, 24'(FIRST_ID - 1));
    send_request(REQ_MAP, 32'h0, 12'd0, 32'h0, 24'(FIRST_ID + VECTORS));
    send_request(REQ_RELEASE_MSI, 32'h7, 12'd4, 32'h0, 24'(FIRST_ID - 2));
    send_request(REQ_RELEASE_MSI, 32'h7, 12'd0, 32'h0, FIRST_ID);
    send_request(REQ_RELEASE_MSI, 32'h9, 12'd10, 32'h0, 24'(FIRST_ID + 1020));
    send_request(REQ_RELEASE_MSI, 32'h7, 12'd10, 32'h0, 24'(FIRST_ID + 1020));
    send_request(REQ_RELEASE_MSI, 32'h7, 12'd1024, 32'h0, FIRST_ID);
    send_request(REQ_ALLOC_MSIX, 32'hB, 12'd0, 32'hFFFF_FFFF, 24'h0);
    send_request(REQ_RELEASE_MSIX, 32'hC, 12'd0, 32'h0, FIRST_ID);
    send_request(REQ_RELEASE_MSIX, 32'hB, 12'd0, 32'h0, FIRST_ID);
    send_request(REQ_RELEASE_MSIX, 32'hB, 12'd0, 32'h0, FIRST_ID);
    send_request(REQ_ALLOC_MSIX, 32'hB, 12'd0, 32'h7, 24'h0);
    drain_results();
    write_register(1'b1, 48'h0);
    send_request(REQ_MAP, 32'h0, 12'd0, 32'h0, FIRST_ID);
    send_request(REQ_RELEASE_MSIX, 32'hB, 12'd0, 32'h0, FIRST_ID);
    drain_results();
  endtask

  task automatic test_random(int unsigned n, int unsigned s_pct, int unsigned r_pct,
                             bit hold_once);
    bit [2:0]  req;
    bit [31:0] dev, ev;
    bit [11:0] count;
    bit [23:0] id;
    int        k;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      if (hold_once && i == n / 2) begin
        in_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      dev = ($urandom_range(9) == 0) ? $urandom() : dev_pool[$urandom_range(3)];
      ev = ($urandom_range(5) == 0) ? $urandom() : $urandom_range(7);
      count = 12'(($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1));
      k = $urandom_range(VECTORS - 1);
      id = 24'(FIRST_ID + k);
      case ($urandom_range(19))
        0, 1, 2, 3, 4: begin
          req = REQ_ALLOC_MSI;
          if ($urandom_range(15) == 0) count = 12'($urandom());
        end
        5, 6, 7, 8, 9: req = REQ_ALLOC_MSIX;
        10, 11, 12: begin
          req = REQ_RELEASE_MSI;
          if (tbl_used[k] && $urandom_range(4) != 0) dev = tbl_dev[k];
          if ($urandom_range(15) == 0) count = 12'($urandom());
        end
        13, 14, 15: begin
          req = REQ_RELEASE_MSIX;
          if (tbl_used[k] && $urandom_range(4) != 0) dev = tbl_dev[k];
        end
        16, 17, 18: req = REQ_MAP;
        default: req = 3'($urandom_range(7, 5));
      endcase
      if ($urandom_range(19) == 0) id = 24'($urandom());
      send_request(req, dev, count, ev, id);
    end
    drain_results();
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_not_ready();
    test_directed();
    write_register(1'b0, $urandom());
    write_register(1'b1, $urandom());
    test_random(90, 37, 72, 1'b1);
    write_register(1'b0, 48'h1);
    write_register(1'b1, 48'h1);
    test_random(90, 72, 37, 1'b0);
    write_register(1'b0, {$urandom(), $urandom()});
    write_register(1'b1, 48'hFFFF_FFFF);
    test_random(90, 0, 0, 1'b0);
    repeat (50) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/msiva_pkg.sv
sv/msiva_ctrl.sv
sv/msiva_dp.sv
sv/msi_vector_allocator.sv
sv/msiva_checker.sv
tb/msi_vector_allocator_tb.sv
